// ===== hw/rtl/bitmap_slot_allocator_macros.svh =====
// Assertion macros for the bitmap slot allocator.
// Each macro expects clk_i and rst_ni to be in scope at the point of use.
`ifndef BITMAP_SLOT_ALLOCATOR_MACROS_SVH
`define BITMAP_SLOT_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define BSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bsa_pkg.sv =====
// Shared constants, codes and types of the bitmap slot allocator.
// No dependencies; bsa_div, bsa_regs and the top level import this package.
`timescale 1ns / 1ps

package bsa_pkg;

  localparam int unsigned SLOTS      = 2048;
  localparam int unsigned ROW_W      = 64;
  localparam int unsigned ROWS       = SLOTS / ROW_W;
  localparam int unsigned ROW_AW     = $clog2(ROWS);
  localparam int unsigned BIT_AW     = $clog2(ROW_W);
  localparam int unsigned IDX_W      = ROW_AW + BIT_AW;
  localparam int unsigned SLOT_IDX_W = 11;
  localparam int unsigned STRIDE_W   = 13;
  localparam int unsigned HANDLE_W   = 64;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned STATUS_W   = 3;
  // offsets at or above 2^OFS_W always map past the last slot
  localparam int unsigned OFS_W      = IDX_W + STRIDE_W;
  localparam int unsigned DIV_CNT_W  = $clog2(OFS_W + 1);
  localparam int unsigned REG_IDX_W  = 2;
  localparam int unsigned APB_DW     = 64;
  localparam int unsigned APB_AW     = REG_IDX_W + 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ALLOCATED = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_DISABLED  = 3'd2,
    STAT_FREED     = 3'd3,
    STAT_REJECTED  = 3'd4
  } status_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_HEAP_ENABLE = 2'd0,
    REG_SLOT_STRIDE = 2'd1,
    REG_CPU_BASE    = 2'd2,
    REG_GPU_BASE    = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_FIND,
    S_A_RD,
    S_A_WR,
    S_A_MUL,
    S_A_ADD,
    S_F_SUB,
    S_F_DIV,
    S_F_RD,
    S_F_WR
  } state_e;

  typedef struct packed {
    logic                heap_enable;
    logic [STRIDE_W-1:0] slot_stride;
    logic [HANDLE_W-1:0] cpu_base;
    logic [HANDLE_W-1:0] gpu_base;
  } cfg_t;

  typedef struct packed {
    logic                start;
    logic [OFS_W-1:0]    dividend;
    logic [STRIDE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [OFS_W-1:0]    quo;
    logic [STRIDE_W-1:0] rem;
  } div_rsp_t;

endpackage

// ===== hw/rtl/bsa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module bsa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/bsa_div.sv =====
// Restoring divider, one quotient bit per cycle, for handle-to-slot mapping.
// Depends on bsa_pkg.
`timescale 1ns / 1ps

module bsa_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bsa_pkg::div_req_t req_i,
  output bsa_pkg::div_rsp_t rsp_o
);
  import bsa_pkg::*;

  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [OFS_W-1:0]     quo_q, quo_d;
  logic [STRIDE_W-1:0]  rem_q, rem_d;
  logic [STRIDE_W-1:0]  dvs_q, dvs_d;
  logic [STRIDE_W:0]    shifted;
  logic [STRIDE_W:0]    diff;
  logic                 ge;

  // one restoring step
  always_comb begin
    shifted = {rem_q, quo_q[OFS_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    ge      = shifted >= {1'b0, dvs_q};
  end

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = DIV_CNT_W'(OFS_W);
      quo_d = req_i.dividend;
      rem_d = '0;
      dvs_d = req_i.divisor;
    end else if (run_q) begin
      quo_d = {quo_q[OFS_W-2:0], ge};
      rem_d = ge ? diff[STRIDE_W-1:0] : shifted[STRIDE_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== hw/rtl/bsa_regs.sv =====
// APB configuration registers of the bitmap slot allocator.
// Depends on bsa_pkg.
`timescale 1ns / 1ps

module bsa_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bsa_pkg::APB_AW-1:0] paddr,
  input  logic [bsa_pkg::APB_DW-1:0] pwdata,
  output logic [bsa_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output bsa_pkg::cfg_t              cfg_o
);
  import bsa_pkg::*;

  cfg_t                 cfg_q;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[APB_AW-1:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_HEAP_ENABLE: cfg_q.heap_enable <= pwdata[0];
        REG_SLOT_STRIDE: cfg_q.slot_stride <= pwdata[STRIDE_W-1:0];
        REG_CPU_BASE:    cfg_q.cpu_base    <= pwdata[HANDLE_W-1:0];
        REG_GPU_BASE:    cfg_q.gpu_base    <= pwdata[HANDLE_W-1:0];
        default:         cfg_q             <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HEAP_ENABLE: prdata = APB_DW'(cfg_q.heap_enable);
      REG_SLOT_STRIDE: prdata = APB_DW'(cfg_q.slot_stride);
      REG_CPU_BASE:    prdata = APB_DW'(cfg_q.cpu_base);
      REG_GPU_BASE:    prdata = APB_DW'(cfg_q.gpu_base);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/bitmap_slot_allocator.sv =====
// Top level of the bitmap slot allocator: sequencer, used-bit map and result register.
// Depends on bsa_pkg, bsa_regs, bsa_div, bsa_ram and the assertion macro header.
`timescale 1ns / 1ps

// A command is taken when start is high and busy is low; exactly one result follows,
// shown for a single cycle with done_o high. The receiver cannot stall, so sample it then.
// Clear, unused command codes, and allocate or free while disabled answer in the cycle
// after the command, without raising busy. Allocate runs a row search over the per-row
// full flags, map RAM read, bit set and write-back, one index-times-stride multiply,
// then the two base adds. A free runs a subtract, then the restoring divider that maps
// the handle offset to a slot at one quotient bit per cycle (24 steps), then read and
// write-back. The used map sits in a 32 x 64 RAM; per-row valid flags make reset and
// clear immediate, so there is no clearing pass.

`include "bitmap_slot_allocator_macros.svh"

module bitmap_slot_allocator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [bsa_pkg::CMD_W-1:0]      cmd_i,
  input  logic [bsa_pkg::HANDLE_W-1:0]   release_handle_i,
  output logic                           done_o,
  output logic [bsa_pkg::STATUS_W-1:0]   status_o,
  output logic [bsa_pkg::HANDLE_W-1:0]   cpu_handle_o,
  output logic [bsa_pkg::HANDLE_W-1:0]   gpu_handle_o,
  output logic [bsa_pkg::SLOT_IDX_W-1:0] slot_index_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bsa_pkg::APB_AW-1:0]     paddr,
  input  logic [bsa_pkg::APB_DW-1:0]     pwdata,
  output logic [bsa_pkg::APB_DW-1:0]     prdata,
  output logic                           pready
);
  import bsa_pkg::*;

  // lowest clear bit of a vector, with a hit flag on top
  function automatic logic [ROW_AW:0] first_clear_row(input logic [ROWS-1:0] v);
    logic [ROW_AW:0] r;
    r = '0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (!v[i]) r = {1'b1, ROW_AW'(i)};
    end
    return r;
  endfunction

  function automatic logic [BIT_AW:0] first_clear_bit(input logic [ROW_W-1:0] v);
    logic [BIT_AW:0] r;
    r = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (!v[i]) r = {1'b1, BIT_AW'(i)};
    end
    return r;
  endfunction

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  state_e state_q, state_d;

  logic [HANDLE_W-1:0] handle_q;
  logic [ROW_AW-1:0]   row_q;
  logic [BIT_AW-1:0]   bit_q;
  logic [OFS_W-1:0]    prod_q;
  logic [ROWS-1:0]     valid_q;
  logic [ROWS-1:0]     full_q;

  logic                  done_q;
  status_e               status_q;
  logic [HANDLE_W-1:0]   cpu_q;
  logic [HANDLE_W-1:0]   gpu_q;
  logic [SLOT_IDX_W-1:0] slot_q;

  logic                accept;
  logic                enabled;
  logic [ROW_AW:0]     row_pick;
  logic                row_hit;
  logic [ROW_W-1:0]    ram_rdata;
  logic [ROW_W-1:0]    word_cur;
  logic [BIT_AW:0]     bit_pick;
  logic [ROW_W-1:0]    word_new;
  logic [HANDLE_W:0]   diff;
  logic                free_bad;
  logic                div_ok;
  logic [IDX_W-1:0]    idx;

  logic                  clear_map;
  logic                  ram_we;
  logic                  res_load;
  status_e               res_status;
  logic [HANDLE_W-1:0]   res_cpu;
  logic [HANDLE_W-1:0]   res_gpu;
  logic [SLOT_IDX_W-1:0] res_slot;

  bsa_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bsa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  bsa_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (row_q),
    .wdata_i (word_new),
    .raddr_i (row_q),
    .rdata_o (ram_rdata)
  );

  assign busy    = state_q != S_IDLE;
  assign accept  = start && !busy;
  assign enabled = cfg.heap_enable && (cfg.slot_stride != '0);
  assign idx     = {row_q, bit_q};

  always_comb begin
    row_pick = first_clear_row(full_q);
    row_hit  = row_pick[ROW_AW];
    // a row never written since reset or clear reads as all free
    word_cur = valid_q[row_q] ? ram_rdata : '0;
    bit_pick = first_clear_bit(word_cur);
    word_new = word_cur;
    if (state_q == S_F_WR) begin
      word_new[bit_q] = 1'b0;
    end else begin
      word_new[bit_pick[BIT_AW-1:0]] = 1'b1;
    end
    diff     = {1'b0, handle_q} - {1'b0, cfg.cpu_base};
    free_bad = (handle_q == '0) || diff[HANDLE_W] || (diff[HANDLE_W-1:OFS_W] != '0);
    div_ok   = (div_rsp.rem == '0) && (div_rsp.quo < OFS_W'(SLOTS));
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_i)
            CMD_ALLOC: state_d = enabled ? S_A_FIND : S_IDLE;
            CMD_FREE:  state_d = enabled ? S_F_SUB : S_IDLE;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_A_FIND: state_d = row_hit ? S_A_RD : S_IDLE;
      S_A_RD:   state_d = S_A_WR;
      S_A_WR:   state_d = S_A_MUL;
      S_A_MUL:  state_d = S_A_ADD;
      S_A_ADD:  state_d = S_IDLE;
      S_F_SUB:  state_d = free_bad ? S_IDLE : S_F_DIV;
      S_F_DIV: begin
        if (div_rsp.done) begin
          state_d = div_ok ? S_F_RD : S_IDLE;
        end
      end
      S_F_RD:   state_d = S_F_WR;
      S_F_WR:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    clear_map        = 1'b0;
    ram_we           = 1'b0;
    res_load         = 1'b0;
    res_status       = STAT_REJECTED;
    res_cpu          = '0;
    res_gpu          = '0;
    res_slot         = '0;
    div_req.start    = 1'b0;
    div_req.dividend = diff[OFS_W-1:0];
    div_req.divisor  = cfg.slot_stride;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_i)
            CMD_CLEAR: begin
              clear_map = 1'b1;
              res_load  = 1'b1;
            end
            CMD_ALLOC, CMD_FREE: begin
              if (!enabled) begin
                res_load   = 1'b1;
                res_status = STAT_DISABLED;
              end
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      S_A_FIND: begin
        if (!row_hit) begin
          res_load   = 1'b1;
          res_status = STAT_FULL;
        end
      end
      S_A_WR: ram_we = 1'b1;
      S_A_ADD: begin
        res_load   = 1'b1;
        res_status = STAT_ALLOCATED;
        res_cpu    = cfg.cpu_base + HANDLE_W'(prod_q);
        res_gpu    = cfg.gpu_base + HANDLE_W'(prod_q);
        res_slot   = SLOT_IDX_W'(idx);
      end
      S_F_SUB: begin
        if (free_bad) begin
          res_load = 1'b1;
        end else begin
          div_req.start = 1'b1;
        end
      end
      S_F_DIV: begin
        if (div_rsp.done && !div_ok) begin
          res_load = 1'b1;
        end
      end
      S_F_WR: begin
        ram_we     = 1'b1;
        res_load   = 1'b1;
        res_status = STAT_FREED;
        res_slot   = SLOT_IDX_W'(idx);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      full_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= res_load;
      if (clear_map) begin
        valid_q <= '0;
        full_q  <= '0;
      end else if (state_q == S_A_WR) begin
        valid_q[row_q] <= 1'b1;
        full_q[row_q]  <= &word_new;
      end else if (state_q == S_F_WR) begin
        valid_q[row_q] <= 1'b1;
        full_q[row_q]  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      handle_q <= release_handle_i;
    end
    if (state_q == S_A_FIND) begin
      row_q <= row_pick[ROW_AW-1:0];
    end
    if (state_q == S_A_WR) begin
      bit_q <= bit_pick[BIT_AW-1:0];
    end
    if (state_q == S_F_DIV && div_rsp.done) begin
      {row_q, bit_q} <= div_rsp.quo[IDX_W-1:0];
    end
    if (state_q == S_A_MUL) begin
      prod_q <= OFS_W'(idx) * OFS_W'(cfg.slot_stride);
    end
    if (res_load) begin
      status_q <= res_status;
      cpu_q    <= res_cpu;
      gpu_q    <= res_gpu;
      slot_q   <= res_slot;
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign cpu_handle_o = cpu_q;
  assign gpu_handle_o = gpu_q;
  assign slot_index_o = slot_q;

  `BSA_ASSERT_NEXT(a_accept_progress, accept, busy || done_o, "accepted beat made no progress")
  `BSA_ASSERT_NOW(a_handles_zero, done_o && (status_o != STAT_ALLOCATED), (cpu_handle_o == '0) && (gpu_handle_o == '0), "nonzero handle without allocation")
  `BSA_ASSERT_NOW(a_div_owner, div_rsp.done, state_q == S_F_DIV, "divider finished outside free")
  `BSA_ASSERT_NOW(a_row_not_full, state_q == S_A_WR, !full_q[row_q], "allocating into a full row")

endmodule

// ===== test/bitmap_slot_allocator_tb.sv =====
// Self-checking testbench for bitmap_slot_allocator: first-fit slot allocation,
// handle-based frees and clears, checked against a shadow used-bit map.
// Depends on bsa_pkg and the bitmap_slot_allocator RTL.
`timescale 1ns / 1ps

module bitmap_slot_allocator_tb;
  import bsa_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned TAIL_CYCLES = 40;

  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [HANDLE_W-1:0] handle;
    bit                  wait_idle;  // hold this beat until all results are back
  } cmd_beat_t;

  typedef struct {
    status_e               status;
    logic [HANDLE_W-1:0]   cpu_handle;
    logic [HANDLE_W-1:0]   gpu_handle;
    logic [SLOT_IDX_W-1:0] slot_index;
  } slot_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [CMD_W-1:0]      cmd_i = '0;
  logic [HANDLE_W-1:0]   release_handle_i = '0;
  logic                  done_o;
  logic [STATUS_W-1:0]   status_o;
  logic [HANDLE_W-1:0]   cpu_handle_o;
  logic [HANDLE_W-1:0]   gpu_handle_o;
  logic [SLOT_IDX_W-1:0] slot_index_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_AW-1:0]     paddr = '0;
  logic [APB_DW-1:0]     pwdata = '0;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;

  cmd_beat_t    cmd_beats_q[$];
  slot_result_t slot_results_q[$];
  cmd_beat_t    cur_beat;
  int unsigned  gap_left = 0;
  int unsigned  quiet_left = 0;
  int unsigned  fail_cnt = 0;

  // shadow copy of the block's state and registers
  bit [SLOTS-1:0] shadow_used = '0;
  cfg_t           shadow_cfg = '0;

  bitmap_slot_allocator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .cmd_i           (cmd_i),
    .release_handle_i(release_handle_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .cpu_handle_o    (cpu_handle_o),
    .gpu_handle_o    (gpu_handle_o),
    .slot_index_o    (slot_index_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [HANDLE_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [HANDLE_W-1:0] slot_addr(longint unsigned k);
    return shadow_cfg.cpu_base + 64'(k) * 64'(shadow_cfg.slot_stride);
  endfunction

  function automatic slot_result_t predict_slot_result(cmd_beat_t b);
    slot_result_t r;
    logic [HANDLE_W-1:0] stride64;
    logic [HANDLE_W-1:0] ofs;
    int unsigned k;
    bit found;
    r.status     = STAT_REJECTED;
    r.cpu_handle = '0;
    r.gpu_handle = '0;
    r.slot_index = '0;
    stride64 = 64'(shadow_cfg.slot_stride);
    found = 1'b0;
    if (b.cmd == CMD_CLEAR) begin
      shadow_used = '0;
    end else if (b.cmd == CMD_UNUSED) begin
      r.status = STAT_REJECTED;
    end else if (!shadow_cfg.heap_enable || shadow_cfg.slot_stride == 0) begin
      r.status = STAT_DISABLED;
    end else if (b.cmd == CMD_ALLOC) begin
      r.status = STAT_FULL;
      for (k = 0; k < SLOTS && !found; k++) begin
        if (!shadow_used[k]) begin
          found          = 1'b1;
          shadow_used[k] = 1'b1;
          r.status       = STAT_ALLOCATED;
          r.cpu_handle   = shadow_cfg.cpu_base + 64'(k) * stride64;
          r.gpu_handle   = shadow_cfg.gpu_base + 64'(k) * stride64;
          r.slot_index   = k[SLOT_IDX_W-1:0];
        end
      end
    end else begin
      ofs = b.handle - shadow_cfg.cpu_base;
      if (b.handle != 0 && b.handle >= shadow_cfg.cpu_base && (ofs % stride64) == 0 &&
          (ofs / stride64) < 64'(SLOTS)) begin
        k              = int'(ofs / stride64);
        shadow_used[k] = 1'b0;
        r.status       = STAT_FREED;
        r.slot_index   = k[SLOT_IDX_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if (r == 0) begin
      quiet_left = $urandom_range(30, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // command driver: start stays high until the beat is taken
  always @(posedge clk_i) begin : drive
    logic nxt_start;
    cmd_beat_t b;
    nxt_start = start;
    if (rst_ni) begin
      if (start && !busy) begin
        slot_results_q.push_back(predict_slot_result(cur_beat));
        nxt_start = 1'b0;
        gap_left  = pick_gap();
      end
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_beats_q.size() != 0 &&
                     !(cmd_beats_q[0].wait_idle && slot_results_q.size() != 0)) begin
          b = cmd_beats_q.pop_front();
          cur_beat = b;
          cmd_i <= b.cmd;
          release_handle_i <= b.handle;
          nxt_start = 1'b1;
        end
      end
    end
    start <= nxt_start;
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt++;
    end
  endtask

  // result monitor: every done_o beat must match the oldest prediction
  always @(posedge clk_i) begin : monitor
    slot_result_t want;
    if (rst_ni && done_o) begin
      if (slot_results_q.size() == 0) begin
        $error("result beat with nothing expected: status %0d", status_o);
        fail_cnt++;
      end else begin
        want = slot_results_q.pop_front();
        check_field("status", 64'(want.status), 64'(status_o));
        check_field("cpu_handle", want.cpu_handle, cpu_handle_o);
        check_field("gpu_handle", want.gpu_handle, gpu_handle_o);
        check_field("slot_index", 64'(want.slot_index), 64'(slot_index_o));
      end
    end
  end

  task automatic push_beat(logic [CMD_W-1:0] c, logic [HANDLE_W-1:0] h, bit hold = 1'b0);
    cmd_beat_t b;
    b.cmd       = c;
    b.handle    = h;
    b.wait_idle = hold;
    cmd_beats_q.push_back(b);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (cmd_beats_q.size() != 0 || start || slot_results_q.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic reg_write(reg_e idx, logic [63:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    case (idx)
      REG_HEAP_ENABLE: shadow_cfg.heap_enable = val[0];
      REG_SLOT_STRIDE: shadow_cfg.slot_stride = val[STRIDE_W-1:0];
      REG_CPU_BASE:    shadow_cfg.cpu_base    = val;
      REG_GPU_BASE:    shadow_cfg.gpu_base    = val;
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_heap(bit en, logic [STRIDE_W-1:0] stride, logic [63:0] cbase,
                          logic [63:0] gbase);
    wait_drained();
    reg_write(REG_HEAP_ENABLE, 64'(en));
    reg_write(REG_SLOT_STRIDE, 64'(stride));
    reg_write(REG_CPU_BASE, cbase);
    reg_write(REG_GPU_BASE, gbase);
  endtask

  initial begin
    int unsigned n;
    int unsigned r;
    int unsigned k;
    int unsigned st;
    logic [63:0] h;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // registers at reset: block is disabled
    push_beat(CMD_ALLOC, '0);
    push_beat(CMD_FREE, 64'h40);
    push_beat(CMD_CLEAR, '1);
    push_beat(CMD_UNUSED, '0);

    // enable low with a stride, then stride zero with enable high
    set_heap(1'b0, 13'd64, 64'h1000, 64'h2000);
    push_beat(CMD_ALLOC, '0);
    push_beat(CMD_FREE, 64'h1000);
    set_heap(1'b1, 13'd0, 64'h1000, 64'h2000);
    push_beat(CMD_ALLOC, '0);

    set_heap(1'b1, 13'd64, 64'h0000_0000_1000_0000, 64'hFFFF_FFFF_FFFF_F000);
    push_beat(CMD_ALLOC, '0);
    push_beat(CMD_ALLOC, '1);
    push_beat(CMD_ALLOC, '0);
    push_beat(CMD_FREE, slot_addr(1));
    push_beat(CMD_FREE, slot_addr(1));          // already free, still accepted
    push_beat(CMD_ALLOC, '0);                   // lowest hole is reused
    push_beat(CMD_FREE, '0);
    push_beat(CMD_FREE, shadow_cfg.cpu_base - 64);
    push_beat(CMD_FREE, shadow_cfg.cpu_base + 1);
    push_beat(CMD_FREE, slot_addr(SLOTS));
    push_beat(CMD_FREE, slot_addr(SLOTS - 1));
    push_beat(CMD_FREE, '1);
    push_beat(CMD_UNUSED, '1);
    push_beat(CMD_CLEAR, '0, 1'b1);
    push_beat(CMD_ALLOC, '0);

    // stride of 4096 with a base near the top: handles wrap
    set_heap(1'b1, 13'd4096, 64'hFFFF_FFFF_FFFF_F000, '0);
    push_beat(CMD_ALLOC, '0);
    push_beat(CMD_FREE, shadow_cfg.cpu_base);
    push_beat(CMD_FREE, '0);
    push_beat(CMD_ALLOC, '0);

    // fill the whole pool at stride one, then punch holes and refill
    set_heap(1'b1, 13'd1, '0, '1);
    for (k = 0; k < SLOTS + 2; k++) push_beat(CMD_ALLOC, rand64());
    push_beat(CMD_FREE, '0);                    // slot zero, but a zero handle
    push_beat(CMD_FREE, 64'd5);
    push_beat(CMD_FREE, 64'd2047);
    push_beat(CMD_FREE, 64'd2048);
    push_beat(CMD_ALLOC, '0);
    push_beat(CMD_ALLOC, '0);
    push_beat(CMD_ALLOC, '0, 1'b1);
    push_beat(CMD_CLEAR, '0);
    push_beat(CMD_ALLOC, '0);

    // the pool fill above already carries most of the item budget
    repeat (10) begin
      r = $urandom_range(0, 9);
      st = (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 4096 : $urandom_range(1, 4096);
      r = $urandom_range(0, 5);
      h = (r == 0) ? '0 : (r == 1) ? ~64'($urandom_range(0, 1 << 20)) : rand64();
      set_heap($urandom_range(0, 9) != 0, st[STRIDE_W-1:0], h, rand64());
      n = $urandom_range(6, 14);
      repeat (n) begin
        r = $urandom_range(0, 99);
        k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SLOTS - 1) : $urandom_range(0, 63);
        if (r < 40) begin
          push_beat(CMD_ALLOC, rand64(), $urandom_range(0, 99) == 0);
        end else if (r < 70) begin
          push_beat(CMD_FREE, slot_addr(k), $urandom_range(0, 99) == 0);
        end else if (r < 80) begin
          if (st > 1) h = slot_addr(k) + $urandom_range(1, st - 1);
          else h = rand64();
          push_beat(CMD_FREE, h);
        end else if (r < 85) begin
          push_beat(CMD_FREE, shadow_cfg.cpu_base - $urandom_range(1, 4096));
        end else if (r < 89) begin
          push_beat(CMD_FREE, slot_addr(SLOTS + $urandom_range(0, 100)));
        end else if (r < 92) begin
          push_beat(CMD_FREE, rand64());
        end else if (r < 94) begin
          push_beat(CMD_FREE, '0);
        end else if (r < 97) begin
          push_beat(CMD_CLEAR, rand64());
        end else begin
          push_beat(CMD_UNUSED, rand64());
        end
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (slot_results_q.size() != 0) begin
      $error("%0d expected results never arrived", slot_results_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
